@@ hdl/nnis_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest-neighbour scaler package
// Shared widths, defaults and the divider request and response types.
// ----------------------------------------------------------------------------
package nnis_pkg;

    // Default frame store geometry and stored channel width
    localparam int DEF_MAX_WIDTH    = 512;
    localparam int DEF_MAX_HEIGHT   = 512;
    localparam int DEF_CHANNEL_BITS = 16;

    // Fixed field widths
    localparam int PIX_W      = 16;
    localparam int COORD_W    = 12;
    localparam int SRC_W      = 10;
    localparam int TGT_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Divider: dividend covers 2*col*sw + outw, divisor covers 2*outw
    localparam int DIV_N_W = 24;
    localparam int DIV_D_W = 14;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [DIV_N_W-1:0] quotient;
    } t_div_rsp;

endpackage

@@ hdl/nnis_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest-neighbour scaler divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nnis_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  nnis_pkg::t_div_req i_req,
    output nnis_pkg::t_div_rsp o_rsp
);
    import nnis_pkg::*;

    localparam int CNT_W = $clog2(DIV_N_W + 1);

    logic [DIV_N_W-1:0] r_quo;
    logic [DIV_D_W-1:0] r_rem;
    logic [DIV_D_W-1:0] r_div;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;

    logic [DIV_D_W:0]   trial;
    logic               q_bit;
    logic [DIV_D_W-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_quo[DIV_N_W-1]};
        q_bit = (trial >= {1'b0, r_div});
        if (q_bit) begin
            n_rem = DIV_D_W'(trial - {1'b0, r_div});
        end else begin
            n_rem = trial[DIV_D_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_N_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            // shift the next dividend bit out into the remainder, the quotient bit in
            r_quo <= {r_quo[DIV_N_W-2:0], q_bit};
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

@@ hdl/nnis_frame_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest-neighbour scaler frame store
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module nnis_frame_mem #(
    parameter int DEPTH = 4,
    parameter int AW    = 2,
    parameter int DW    = 8
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/nearest_neighbor_image_scaler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest-neighbour image scaler
// Stores a source frame of HSLA pixels and answers reads of an
// aspect-preserving rescaled frame by nearest-neighbour selection.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                    Payload
//  -------  ---------  ---------------------------  ---------------------------
//  in       sink       i_in_valid / o_in_stall      action, column, line, HSLA
//  out      source     o_out_valid / i_out_stall    HSLA, scaled size, flag
//  cfg      sink       i_cfg_we                     i_cfg_index, i_cfg_data
//
//  A pixel write goes straight into the store on transfer. A read passes
//  twice through the shared 24-step divider (column then row), and the
//  first read after a configuration write first recomputes the scaled size
//  through the same divider. Out-of-frame reads skip the two divisions.
//  Reset is synchronous, active low; the frame store is not cleared.
//  One finished result may wait in the output register while the next item
//  is taken; a read stalls only in its output state if that result is held.
// ----------------------------------------------------------------------------
module nearest_neighbor_image_scaler #(
    parameter int MAX_WIDTH    = nnis_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = nnis_pkg::DEF_MAX_HEIGHT,
    parameter int CHANNEL_BITS = nnis_pkg::DEF_CHANNEL_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input item channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_action,
    input  logic [nnis_pkg::COORD_W-1:0]    i_column,
    input  logic [nnis_pkg::COORD_W-1:0]    i_line,
    input  logic [nnis_pkg::PIX_W-1:0]      i_hue_in,
    input  logic [nnis_pkg::PIX_W-1:0]      i_saturation_in,
    input  logic [nnis_pkg::PIX_W-1:0]      i_lightness_in,
    input  logic [nnis_pkg::PIX_W-1:0]      i_alpha_in,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [nnis_pkg::PIX_W-1:0]      o_hue_out,
    output logic [nnis_pkg::PIX_W-1:0]      o_saturation_out,
    output logic [nnis_pkg::PIX_W-1:0]      o_lightness_out,
    output logic [nnis_pkg::PIX_W-1:0]      o_alpha_out,
    output logic [nnis_pkg::TGT_W-1:0]      o_scaled_width,
    output logic [nnis_pkg::TGT_W-1:0]      o_scaled_height,
    output logic                            o_out_of_frame,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [nnis_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [nnis_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import nnis_pkg::*;

    localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DW      = 4 * CHANNEL_BITS;
    localparam int TGT_MAX = 4096;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TGT_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TGT_HEIGHT = 2'd3;

    // item actions
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_MUL   = 8'b0000_0010,
        S_CMP   = 8'b0000_0100,
        S_SIZE  = 8'b0000_1000,
        S_CHECK = 8'b0001_0000,
        S_XDIV  = 8'b0010_0000,
        S_YDIV  = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic [SRC_W-1:0] r_src_w, r_src_h;
    logic [TGT_W-1:0] r_tgt_w, r_tgt_h;
    logic             r_size_stale;

    // cached scaled size and its intermediates
    logic [TGT_W-1:0]   r_out_w, r_out_h;
    logic [2*SRC_W+2:0] r_prod_a, r_prod_b;
    logic               r_fit_w;

    // read item in progress
    logic [COORD_W-1:0] r_col, r_row;
    logic               r_outside;
    logic [SRC_W-1:0]   r_sx;

    // output register
    logic               r_out_valid;
    logic [PIX_W-1:0]   r_hue, r_sat, r_light, r_alpha;
    logic [TGT_W-1:0]   r_res_w, r_res_h;
    logic               r_res_flag;

    // effective, saturated register values
    logic [TGT_W-1:0] sw_wide, sh_wide;
    logic [SRC_W-1:0] eff_sw, eff_sh;
    logic [TGT_W-1:0] eff_tw, eff_th;

    logic       in_accept;
    logic       in_src;
    logic       out_free;
    logic       outside;
    logic       fit_w;
    t_div_req   div_req;
    t_div_rsp   div_rsp;
    logic [SRC_W-1:0] sx_clamped, sy_clamped;
    logic [2*COORD_W-3:0] x_prod, y_prod;

    logic          mem_wr_en;
    logic [31:0]   wr_addr_full, rd_addr_full;
    logic          mem_rd_en;
    logic [DW-1:0] wr_data, rd_data;

    // ---- saturate the configuration to its legal range ----
    always_comb begin
        sw_wide = TGT_W'(r_src_w);
        sh_wide = TGT_W'(r_src_h);
        if (sw_wide == '0) begin
            sw_wide = TGT_W'(1);
        end else if (32'(sw_wide) > 32'(MAX_WIDTH)) begin
            sw_wide = TGT_W'(MAX_WIDTH);
        end
        if (sh_wide == '0) begin
            sh_wide = TGT_W'(1);
        end else if (32'(sh_wide) > 32'(MAX_HEIGHT)) begin
            sh_wide = TGT_W'(MAX_HEIGHT);
        end
        eff_sw = sw_wide[SRC_W-1:0];
        eff_sh = sh_wide[SRC_W-1:0];
        eff_tw = (32'(r_tgt_w) > TGT_MAX) ? TGT_W'(TGT_MAX) : r_tgt_w;
        eff_th = (32'(r_tgt_h) > TGT_MAX) ? TGT_W'(TGT_MAX) : r_tgt_h;
    end

    // ---- configuration writes; mark the cached size stale ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= SRC_W'(1);
            r_src_h <= SRC_W'(1);
            r_tgt_w <= TGT_W'(1);
            r_tgt_h <= TGT_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SRC_WIDTH:  r_src_w <= i_cfg_data[SRC_W-1:0];
                CFG_SRC_HEIGHT: r_src_h <= i_cfg_data[SRC_W-1:0];
                CFG_TGT_WIDTH:  r_tgt_w <= i_cfg_data[TGT_W-1:0];
                CFG_TGT_HEIGHT: r_tgt_h <= i_cfg_data[TGT_W-1:0];
                default: ;
            endcase
        end
    end

    // ---- handshakes ----
    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // ---- source pixel write, straight into the store on transfer ----
    assign in_src       = (i_column < COORD_W'(eff_sw)) && (i_line < COORD_W'(eff_sh));
    assign mem_wr_en    = in_accept && (i_action == ACT_WRITE) && in_src;
    assign wr_addr_full = 32'(i_line) * 32'(MAX_WIDTH) + 32'(i_column);
    assign wr_data      = {i_alpha_in[CHANNEL_BITS-1:0], i_lightness_in[CHANNEL_BITS-1:0],
                           i_saturation_in[CHANNEL_BITS-1:0], i_hue_in[CHANNEL_BITS-1:0]};

    // ---- read datapath helpers ----
    assign fit_w   = (r_prod_a <= r_prod_b);
    assign outside = ({1'b0, r_col} >= r_out_w) || ({1'b0, r_row} >= r_out_h);
    assign x_prod  = (2*COORD_W-2)'(r_col) * (2*COORD_W-2)'(eff_sw);
    assign y_prod  = (2*COORD_W-2)'(r_row) * (2*COORD_W-2)'(eff_sh);

    // clamp the rounded index to the last source column or row
    always_comb begin
        if (div_rsp.quotient > DIV_N_W'(eff_sw - 1'b1)) begin
            sx_clamped = eff_sw - 1'b1;
        end else begin
            sx_clamped = div_rsp.quotient[SRC_W-1:0];
        end
        if (div_rsp.quotient > DIV_N_W'(eff_sh - 1'b1)) begin
            sy_clamped = eff_sh - 1'b1;
        end else begin
            sy_clamped = div_rsp.quotient[SRC_W-1:0];
        end
    end

    assign rd_addr_full = 32'(sy_clamped) * 32'(MAX_WIDTH) + 32'(r_sx);

    // ---- sequencer ----
    always_comb begin
        n_state          = r_state;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        mem_rd_en        = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_accept && (i_action == ACT_READ)) begin
                    n_state = r_size_stale ? S_MUL : S_CHECK;
                end
            end
            S_MUL: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                // height follows width when the width ratio is the smaller one
                div_req.start = 1'b1;
                if (fit_w) begin
                    div_req.dividend = DIV_N_W'(r_prod_a);
                    div_req.divisor  = DIV_D_W'(eff_sw);
                end else begin
                    div_req.dividend = DIV_N_W'(r_prod_b);
                    div_req.divisor  = DIV_D_W'(eff_sh);
                end
                n_state = S_SIZE;
            end
            S_SIZE: begin
                if (div_rsp.done) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (outside) begin
                    n_state = S_OUT;
                end else begin
                    // round half up: (2*col*sw + outw) / (2*outw)
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_N_W'({x_prod, 1'b0}) + DIV_N_W'(r_out_w);
                    div_req.divisor  = {r_out_w, 1'b0};
                    n_state          = S_XDIV;
                end
            end
            S_XDIV: begin
                if (div_rsp.done) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_N_W'({y_prod, 1'b0}) + DIV_N_W'(r_out_h);
                    div_req.divisor  = {r_out_h, 1'b0};
                    n_state          = S_YDIV;
                end
            end
            S_YDIV: begin
                if (div_rsp.done) begin
                    mem_rd_en = 1'b1;
                    n_state   = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_size_stale <= 1'b1;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_size_stale <= 1'b1;
            end else if ((r_state == S_SIZE) && div_rsp.done) begin
                r_size_stale <= 1'b0;
            end
            if ((r_state == S_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---- datapath registers ----
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_col <= i_column;
            r_row <= i_line;
        end
        if (r_state == S_MUL) begin
            r_prod_a <= (2*SRC_W+3)'(eff_tw) * (2*SRC_W+3)'(eff_sh);
            r_prod_b <= (2*SRC_W+3)'(eff_th) * (2*SRC_W+3)'(eff_sw);
        end
        if (r_state == S_CMP) begin
            r_fit_w <= fit_w;
        end
        if ((r_state == S_SIZE) && div_rsp.done) begin
            if (r_fit_w) begin
                r_out_w <= eff_tw;
                r_out_h <= div_rsp.quotient[TGT_W-1:0];
            end else begin
                r_out_w <= div_rsp.quotient[TGT_W-1:0];
                r_out_h <= eff_th;
            end
        end
        if (r_state == S_CHECK) begin
            r_outside <= outside;
        end
        if ((r_state == S_XDIV) && div_rsp.done) begin
            r_sx <= sx_clamped;
        end
        // load the result; out-of-frame reads give zero channels
        if ((r_state == S_OUT) && out_free) begin
            if (r_outside) begin
                r_hue   <= '0;
                r_sat   <= '0;
                r_light <= '0;
                r_alpha <= '0;
            end else begin
                r_hue   <= PIX_W'(rd_data[CHANNEL_BITS-1:0]);
                r_sat   <= PIX_W'(rd_data[2*CHANNEL_BITS-1:CHANNEL_BITS]);
                r_light <= PIX_W'(rd_data[3*CHANNEL_BITS-1:2*CHANNEL_BITS]);
                r_alpha <= PIX_W'(rd_data[4*CHANNEL_BITS-1:3*CHANNEL_BITS]);
            end
            r_res_w    <= r_out_w;
            r_res_h    <= r_out_h;
            r_res_flag <= r_outside;
        end
    end

    // ---- shared divider and frame store ----
    nnis_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    nnis_frame_mem #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (DW)
    ) u_frame_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (wr_addr_full[AW-1:0]),
        .i_wr_data (wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (rd_addr_full[AW-1:0]),
        .o_rd_data (rd_data)
    );

    // ---- outputs ----
    assign o_out_valid      = r_out_valid;
    assign o_hue_out        = r_hue;
    assign o_saturation_out = r_sat;
    assign o_lightness_out  = r_light;
    assign o_alpha_out      = r_alpha;
    assign o_scaled_width   = r_res_w;
    assign o_scaled_height  = r_res_h;
    assign o_out_of_frame   = r_res_flag;

endmodule
